FILE: hdl/rtec_pkg.sv
`default_nettype none

package rtec_pkg;

	localparam int AP_SLOTS = 64;
	localparam int SLOT_W   = $clog2(AP_SLOTS);
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UTIL_HIGH  = 2'd0,
		CFG_UTIL_RUN   = 2'd1,
		CFG_NOISE_RISE = 2'd2
	} cfg_idx_t;

	localparam logic [7:0] DEF_UTIL_HIGH  = 8'd85;
	localparam logic [7:0] DEF_UTIL_RUN   = 8'd3;
	localparam logic [7:0] DEF_NOISE_RISE = 8'd10;

	localparam logic [7:0]        LOAD_MAX  = 8'd100;
	localparam logic signed [7:0] NOISE_MIN = -8'sd120;
	localparam logic signed [7:0] NOISE_MAX = 8'sd0;
	localparam logic [31:0]       COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_REJECT = 2'd0,
		ST_INIT   = 2'd1,
		ST_CLASS  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_RADAR = 2'd1,
		EV_LOAD  = 2'd2,
		EV_NOISE = 2'd3
	} kind_t;

	typedef enum logic {
		CS_IDLE,
		CS_CALC
	} ctrl_state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;  // latch request, launch slot table read
		logic execute;  // classify, write back, load result registers
	} dp_cmd_t;

	// one slot table entry
	typedef struct packed {
		logic [7:0]        avg;
		logic signed [7:0] noise;
		logic [7:0]        run;
		logic [31:0]       pkts;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	function automatic logic chan_legal(input logic [7:0] c);
		logic m4;
		m4 = (c[1:0] == 2'b00);
		return (c >= 8'd1 && c <= 8'd14)
			|| (m4 && c >= 8'd36 && c <= 8'd64)
			|| (m4 && c >= 8'd100 && c <= 8'd144)
			|| (m4 && c >= 8'd149 && c <= 8'd161)
			|| (c == 8'd165);
	endfunction

	function automatic logic chan_dfs(input logic [7:0] c);
		return (c[1:0] == 2'b00)
			&& ((c >= 8'd52 && c <= 8'd64) || (c >= 8'd100 && c <= 8'd144));
	endfunction

endpackage

`default_nettype wire

FILE: hdl/rtec_ram.sv
`default_nettype none

module rtec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rtec_ctrl.sv
`default_nettype none

module rtec_ctrl
	import rtec_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output dp_cmd_t   cmd
);

	ctrl_state_t state_q, state_d;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.execute;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		busy        = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = CS_CALC;
				end
			end
			CS_CALC: begin
				busy        = 1'b1;
				cmd.execute = 1'b1;
				state_d     = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	assign done = done_q;

	// result strobe only ever follows a calc cycle
	a_done_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == CS_CALC))
		else $error("result strobe without a calc cycle");

	// every accepted request produces a strobe, via the calc state and the done register
	a_req_gets_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted request lost its result");

	// no new capture while a request is in calc
	a_no_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.capture)
		else $error("capture while busy");

endmodule

`default_nettype wire

FILE: hdl/rtec_dp.sv
`default_nettype none

module rtec_dp
	import rtec_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic [SLOT_W-1:0]    ap_slot,
	input  wire logic [31:0]          ap_ident,
	input  wire logic [7:0]           radio_channel,
	input  wire logic [7:0]           channel_load,
	input  wire logic signed [7:0]    noise_dbm,
	input  wire logic                 radar_seen,
	output logic [1:0]                report_status,
	output logic [1:0]                event_kind,
	output logic [31:0]               event_ap,
	output logic [7:0]                event_channel,
	output logic [7:0]                load_average,
	output logic signed [7:0]         report_noise,
	output logic [31:0]               slot_packets,
	output logic [31:0]               invalid_total
);

	// configuration
	logic [7:0] util_high_q, util_run_q, noise_rise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			util_high_q  <= '0;
			util_run_q   <= '0;
			noise_rise_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_UTIL_HIGH:  util_high_q  <= cfg_wdata;
				CFG_UTIL_RUN:   util_run_q   <= cfg_wdata;
				CFG_NOISE_RISE: noise_rise_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured request
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       ident_q;
	logic [7:0]        chan_q, load_q;
	logic signed [7:0] noise_q;
	logic              radar_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q  <= ap_slot;
			ident_q <= ap_ident;
			chan_q  <= radio_channel;
			load_q  <= channel_load;
			noise_q <= noise_dbm;
			radar_q <= radar_seen;
		end
	end

	// slot table, read launched on capture
	logic [REC_W-1:0] rd_word, wr_word;
	slot_rec_t        old_rec, new_rec;
	logic             tbl_we;

	rtec_ram #(
		.WIDTH (REC_W),
		.DEPTH (AP_SLOTS)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (slot_q),
		.wdata (wr_word),
		.re    (cmd.capture),
		.raddr (ap_slot),
		.rdata (rd_word)
	);

	assign old_rec = slot_rec_t'(rd_word);
	assign wr_word = REC_W'(new_rec);

	logic [AP_SLOTS-1:0] slot_valid_q;
	logic [31:0]         reject_q;

	// validity and classification
	logic              report_ok, in_range, was_valid;
	logic [7:0]        hi_lim, run_lim, rise_lim;
	logic [9:0]        avg_sum;
	logic [7:0]        avg_new;
	logic [8:0]        run_inc;
	logic signed [9:0] rise;
	logic [7:0]        run_new;
	kind_t             kind;
	status_t           status;

	assign in_range  = ({1'b0, slot_q} < (SLOT_W + 1)'(AP_SLOTS));
	assign report_ok = in_range && chan_legal(chan_q) && (load_q <= LOAD_MAX)
		&& (noise_q >= NOISE_MIN) && (noise_q <= NOISE_MAX);
	assign was_valid = slot_valid_q[slot_q];

	assign hi_lim   = (util_high_q  != 8'd0) ? util_high_q  : DEF_UTIL_HIGH;
	assign run_lim  = (util_run_q   != 8'd0) ? util_run_q   : DEF_UTIL_RUN;
	assign rise_lim = (noise_rise_q != 8'd0) ? noise_rise_q : DEF_NOISE_RISE;

	// 1/4 new + 3/4 old, truncated
	assign avg_sum = {2'b00, load_q} + {2'b00, old_rec.avg} + {1'b0, old_rec.avg, 1'b0};
	assign avg_new = avg_sum[9:2];
	assign run_inc = {1'b0, old_rec.run} + 9'd1;
	assign rise    = 10'(signed'(noise_q)) - 10'(signed'(old_rec.noise));

	always_comb begin
		kind    = EV_NONE;
		run_new = 8'd0;
		if (radar_q && chan_dfs(chan_q)) begin
			kind = EV_RADAR;
		end else if (avg_new >= hi_lim) begin
			run_new = run_inc[7:0];
			if (run_inc >= {1'b0, run_lim}) begin
				kind    = EV_LOAD;
				run_new = run_lim;
			end
		end else if (rise > $signed({2'b00, rise_lim})) begin
			kind = EV_NOISE;
		end
	end

	always_comb begin
		new_rec = old_rec;
		tbl_we  = 1'b0;
		status  = ST_REJECT;
		if (report_ok) begin
			tbl_we = cmd.execute;
			if (!was_valid) begin
				status        = ST_INIT;
				new_rec.avg   = load_q;
				new_rec.noise = noise_q;
				new_rec.run   = 8'd0;
				new_rec.pkts  = 32'd1;
			end else begin
				status        = ST_CLASS;
				new_rec.avg   = avg_new;
				new_rec.noise = noise_q;
				new_rec.run   = run_new;
				new_rec.pkts  = (old_rec.pkts != COUNT_MAX) ? old_rec.pkts + 32'd1
					: old_rec.pkts;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			reject_q     <= '0;
		end else if (cmd.execute) begin
			if (report_ok) begin
				slot_valid_q[slot_q] <= 1'b1;
			end else if (reject_q != COUNT_MAX) begin
				reject_q <= reject_q + 32'd1;
			end
		end
	end

	// result registers
	logic [1:0]        status_q, kind_q;
	logic [31:0]       ap_q, pkts_q;
	logic [7:0]        chan_out_q, avg_q;
	logic signed [7:0] noise_out_q;

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q    <= status;
			ap_q        <= ident_q;
			chan_out_q  <= chan_q;
			noise_out_q <= noise_q;
			unique case (status)
				ST_CLASS: begin
					kind_q <= kind;
					avg_q  <= new_rec.avg;
					pkts_q <= new_rec.pkts;
				end
				ST_INIT: begin
					kind_q <= EV_NONE;
					avg_q  <= new_rec.avg;
					pkts_q <= new_rec.pkts;
				end
				default: begin
					kind_q <= EV_NONE;
					avg_q  <= 8'd0;
					pkts_q <= 32'd0;
				end
			endcase
		end
	end

	assign report_status = status_q;
	assign event_kind    = kind_q;
	assign event_ap      = ap_q;
	assign event_channel = chan_out_q;
	assign load_average  = avg_q;
	assign report_noise  = noise_out_q;
	assign slot_packets  = pkts_q;
	// reject counter is visible after the request that moved it
	assign invalid_total = reject_q;

endmodule

`default_nettype wire

FILE: hdl/rf_telemetry_event_classifier_core.sv
// Channel   Direction  Signals                                        Handshake
// request   in         ap_slot ap_ident radio_channel channel_load   start / busy
//                      noise_dbm radar_seen
// result    out        report_status event_kind event_ap             done (1 cycle)
//                      event_channel load_average report_noise
//                      slot_packets invalid_total
// config    in         cfg_index cfg_wdata                           cfg_wr_en
//
// A request is taken on the edge where start is high and busy is low; that edge
// launches the slot table read. The next cycle (busy high) classifies and writes
// the slot back; the result shows in the cycle after, with done high. No new
// request is taken while busy, that is while the slot is written back.
// Reset (arst_n low, async) clears slot valid bits, reject counter and limits.
// done cannot be held off; a new request may be taken while done is high.
`default_nettype none

module rf_telemetry_event_classifier_core
	import rtec_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [SLOT_W-1:0]    ap_slot,
	input  wire logic [31:0]          ap_ident,
	input  wire logic [7:0]           radio_channel,
	input  wire logic [7:0]           channel_load,
	input  wire logic signed [7:0]    noise_dbm,
	input  wire logic                 radar_seen,
	// configuration write port
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	// result
	output logic                      done,
	output logic [1:0]                report_status,
	output logic [1:0]                event_kind,
	output logic [31:0]               event_ap,
	output logic [7:0]                event_channel,
	output logic [7:0]                load_average,
	output logic signed [7:0]         report_noise,
	output logic [31:0]               slot_packets,
	output logic [31:0]               invalid_total
);

	dp_cmd_t cmd;

	// sequencer: idle -> calc -> idle, done registered off calc
	rtec_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// slot table, limits, classifier and result registers
	rtec_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.ap_slot       (ap_slot),
		.ap_ident      (ap_ident),
		.radio_channel (radio_channel),
		.channel_load  (channel_load),
		.noise_dbm     (noise_dbm),
		.radar_seen    (radar_seen),
		.report_status (report_status),
		.event_kind    (event_kind),
		.event_ap      (event_ap),
		.event_channel (event_channel),
		.load_average  (load_average),
		.report_noise  (report_noise),
		.slot_packets  (slot_packets),
		.invalid_total (invalid_total)
	);

endmodule

`default_nettype wire
